FILE: hw/rtl/sqmm_pkg.sv
// Shared types and constants for the square matrix multiplier.
// Used by the channel interfaces, the MAC unit and the top level.
package sqmm_pkg;

   localparam int DEFAULT_MAX_ORDER     = 8;
   localparam int DEFAULT_FRACTION_BITS = 16;

   localparam int ELEMENT_W = 32;
   localparam int SIZE_W    = 4;

   localparam logic [SIZE_W-1:0] RESET_SIZE = 4'd8;

   // word kind on the request channel
   localparam logic KIND_LEFT  = 1'b0;
   localparam logic KIND_RIGHT = 1'b1;

   // tags that travel with each operand pair through the MAC pipeline
   typedef struct packed {
      logic valid;
      logic first;   // first term of a dot product
      logic last;    // last term of a dot product
      logic fin;     // last term of the whole product
   } mac_ctl_type;

   // one finished entry leaving the MAC unit
   typedef struct packed {
      logic                        valid;
      logic                        fin;
      logic signed [ELEMENT_W-1:0] data;
   } mac_res_type;

endpackage

FILE: hw/rtl/sqmm_req_if.sv
// Request channel of the square matrix multiplier: one matrix element a word.
// Depends on sqmm_pkg for the element width.
interface sqmm_req_if;
   import sqmm_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic signed [ELEMENT_W-1:0] element;

   modport source (output valid, output kind, output element, input ready);
   modport sink   (input valid, input kind, input element, output ready);
endinterface

FILE: hw/rtl/sqmm_rsp_if.sv
// Response channel of the square matrix multiplier: one entry of C a word.
// Depends on sqmm_pkg for the element width.
interface sqmm_rsp_if;
   import sqmm_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [ELEMENT_W-1:0] product_entry;
   logic                        last_entry;

   modport source (output valid, output product_entry, output last_entry, input ready);
   modport sink   (input valid, input product_entry, input last_entry, output ready);
endinterface

FILE: hw/rtl/square_matrix_multiply.sv
// Square matrix multiplier C = A*B, signed fixed point, one shared MAC.
// Depends on sqmm_pkg, sqmm_req_if, sqmm_rsp_if and sqmm_mac.
//
//  channel   dir  word                      handshake
//  req_bus   in   kind, element             valid/ready
//  rsp_bus   out  product_entry, last_entry valid/ready
//  csr_*     in   matrix_size (4 bits)      write enable, no wait
//
// A loading word that returns the next entry of C goes through the product
// memory read, then the output register.
// The word that completes B starts the product: the single multiplier
// does one term per cycle, followed by a multiply/accumulate/round tail.
// Reset is synchronous: counts cleared, size back to 8, no entries pending.
// A stalled response holds the sequencer in its push state; req_bus.ready is low until it moves.
module square_matrix_multiply #(
   parameter int MAX_ORDER     = sqmm_pkg::DEFAULT_MAX_ORDER,
   parameter int FRACTION_BITS = sqmm_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   sqmm_req_if.sink                     req_bus,
   sqmm_rsp_if.source                   rsp_bus,
   input  logic                         csr_write_enable,
   input  logic [sqmm_pkg::SIZE_W-1:0]  csr_write_data
);
   import sqmm_pkg::*;

   localparam int CELLS  = MAX_ORDER * MAX_ORDER;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int ORD_W  = $clog2(MAX_ORDER + 1);
   localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ISSUE = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_FETCH = 5'b01000,
      ST_PUSH  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [SIZE_W-1:0]      size_ff;
   logic [ORD_W-1:0]       order_now, order_ff, order_in;
   logic [CNT_W-1:0]       cells_now;
   logic [CNT_W-1:0]       left_cnt_ff, left_cnt_in, right_cnt_ff, right_cnt_in;
   logic [CNT_W-1:0]       right_cnt_next;
   logic [CNT_W-1:0]       emit_idx_ff, emit_idx_in, emit_total_ff, emit_total_in;
   logic [IDX_W-1:0]       i_ff, i_in, j_ff, j_in, k_ff, k_in, ord_last;
   logic [ADDR_W-1:0]      la_ff, la_in, rb_ff, rb_in, row_ff, row_in, wp_ff, wp_in;
   logic [ADDR_W-1:0]      order_addr;
   logic                   accept, left_we, right_we;
   logic                   last_rd_ff, last_rd_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic signed [ELEMENT_W-1:0] rsp_data_ff, rsp_data_in;
   logic signed [ELEMENT_W-1:0] prod_rd_ff;
   logic signed [ELEMENT_W-1:0] left_rd_ff, right_rd_ff;
   mac_ctl_type            issue_ctl, ctl_rd_ff;
   mac_res_type            mac_res;

   logic signed [ELEMENT_W-1:0] left_mem  [CELLS];
   logic signed [ELEMENT_W-1:0] right_mem [CELLS];
   logic signed [ELEMENT_W-1:0] prod_mem  [CELLS];

   // effective order: 0 acts as 1, oversize clamps to the maximum
   always_comb begin
      if (size_ff == '0) begin
         order_now = ORD_W'(1);
      end else if (size_ff > SIZE_W'(MAX_ORDER)) begin
         order_now = ORD_W'(MAX_ORDER);
      end else begin
         order_now = ORD_W'(size_ff);
      end
   end

   assign cells_now  = CNT_W'(order_now) * CNT_W'(order_now);
   assign ord_last   = IDX_W'(order_ff - ORD_W'(1));
   assign order_addr = ADDR_W'(order_ff);

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && (state_ff == ST_IDLE);

   assign left_we  = accept && (req_bus.kind == KIND_LEFT) && (left_cnt_ff < cells_now);
   assign right_we = accept && (req_bus.kind == KIND_RIGHT) && (left_cnt_ff >= cells_now)
                     && (right_cnt_ff != CNT_W'(CELLS));
   assign right_cnt_next = right_we ? right_cnt_ff + CNT_W'(1) : right_cnt_ff;

   assign issue_ctl.valid = (state_ff == ST_ISSUE);
   assign issue_ctl.first = (k_ff == '0);
   assign issue_ctl.last  = (k_ff == ord_last);
   assign issue_ctl.fin   = (k_ff == ord_last) && (j_ff == ord_last) && (i_ff == ord_last);

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.product_entry = rsp_data_ff;
   assign rsp_bus.last_entry    = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      order_in      = order_ff;
      left_cnt_in   = left_cnt_ff;
      right_cnt_in  = right_cnt_ff;
      emit_idx_in   = emit_idx_ff;
      emit_total_in = emit_total_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      la_in         = la_ff;
      rb_in         = rb_ff;
      row_in        = row_ff;
      wp_in         = mac_res.valid ? wp_ff + ADDR_W'(1) : wp_ff;
      last_rd_in    = last_rd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (left_we) begin
                  left_cnt_in = left_cnt_ff + CNT_W'(1);
               end
               right_cnt_in = right_cnt_next;
               if (req_bus.kind == KIND_RIGHT && left_cnt_ff >= cells_now
                   && right_cnt_next >= cells_now) begin
                  // operands complete: start the product
                  left_cnt_in   = '0;
                  right_cnt_in  = '0;
                  order_in      = order_now;
                  emit_idx_in   = '0;
                  emit_total_in = cells_now;
                  i_in          = '0;
                  j_in          = '0;
                  k_in          = '0;
                  la_in         = '0;
                  rb_in         = '0;
                  row_in        = '0;
                  wp_in         = '0;
                  state_in      = ST_ISSUE;
               end else if (emit_idx_ff < emit_total_ff) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_ISSUE: begin
            if (k_ff != ord_last) begin
               k_in  = k_ff + IDX_W'(1);
               la_in = la_ff + ADDR_W'(1);
               rb_in = rb_ff + order_addr;
            end else begin
               k_in = '0;
               if (j_ff != ord_last) begin
                  j_in  = j_ff + IDX_W'(1);
                  la_in = row_ff;
                  rb_in = ADDR_W'(j_ff) + ADDR_W'(1);
               end else begin
                  j_in   = '0;
                  i_in   = i_ff + IDX_W'(1);
                  row_in = row_ff + order_addr;
                  la_in  = row_ff + order_addr;
                  rb_in  = '0;
                  if (i_ff == ord_last) begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (mac_res.valid && mac_res.fin) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            last_rd_in  = (emit_idx_ff + CNT_W'(1) == emit_total_ff);
            emit_idx_in = emit_idx_ff + CNT_W'(1);
            state_in    = ST_PUSH;
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = prod_rd_ff;
               rsp_last_in  = last_rd_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         size_ff       <= RESET_SIZE;
         left_cnt_ff   <= '0;
         right_cnt_ff  <= '0;
         emit_idx_ff   <= '0;
         emit_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         ctl_rd_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
         end
         left_cnt_ff   <= left_cnt_in;
         right_cnt_ff  <= right_cnt_in;
         emit_idx_ff   <= emit_idx_in;
         emit_total_ff <= emit_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         ctl_rd_ff     <= issue_ctl;
      end
   end

   always_ff @(posedge clock) begin
      order_ff    <= order_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      la_ff       <= la_in;
      rb_ff       <= rb_in;
      row_ff      <= row_in;
      wp_ff       <= wp_in;
      last_rd_ff  <= last_rd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // operand memories
   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[left_cnt_ff[ADDR_W-1:0]] <= req_bus.element;
      end
      if (right_we) begin
         right_mem[right_cnt_ff[ADDR_W-1:0]] <= req_bus.element;
      end
      left_rd_ff  <= left_mem[la_ff];
      right_rd_ff <= right_mem[rb_ff];
   end

   // result memory
   always_ff @(posedge clock) begin
      if (mac_res.valid) begin
         prod_mem[wp_ff] <= mac_res.data;
      end
      if (state_ff == ST_FETCH) begin
         prod_rd_ff <= prod_mem[emit_idx_ff[ADDR_W-1:0]];
      end
   end

   sqmm_mac #(
      .MAX_ORDER     (MAX_ORDER),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .op_ctl   (ctl_rd_ff),
      .op_left  (left_rd_ff),
      .op_right (right_rd_ff),
      .result   (mac_res)
   );

endmodule

FILE: hw/rtl/sqmm_mac.sv
// Shared multiply-accumulate unit: multiply, accumulate, round, saturate.
// Depends on sqmm_pkg for the control and result structs.
module sqmm_mac #(
   parameter int MAX_ORDER     = sqmm_pkg::DEFAULT_MAX_ORDER,
   parameter int FRACTION_BITS = sqmm_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sqmm_pkg::mac_ctl_type                 op_ctl,
   input  logic signed [sqmm_pkg::ELEMENT_W-1:0] op_left,
   input  logic signed [sqmm_pkg::ELEMENT_W-1:0] op_right,
   output sqmm_pkg::mac_res_type                 result
);
   import sqmm_pkg::*;

   localparam int PROD_W = 2 * ELEMENT_W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_ORDER) + 1;
   localparam logic signed [ACC_W-1:0] HALF = (ACC_W'(1) << FRACTION_BITS) >> 1;

   mac_ctl_type               ctl_mul_ff, ctl_acc_ff;
   logic                      rnd_valid_ff, rnd_fin_ff;
   logic signed [PROD_W-1:0]  mul_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   rnd_ff;
   logic signed [ACC_W-1:0]   shifted;
   logic [ACC_W-32:0]         upper;
   logic signed [ELEMENT_W-1:0] sat_data;

   always_comb begin
      if (ctl_mul_ff.first) begin
         acc_in = ACC_W'(mul_ff);
      end else begin
         acc_in = acc_ff + ACC_W'(mul_ff);
      end
   end

   // round to nearest (ties up) already added; clamp to 32 bits
   always_comb begin
      shifted = rnd_ff >>> FRACTION_BITS;
      upper   = shifted[ACC_W-1:ELEMENT_W-1];
      if ((&upper) || !(|upper)) begin
         sat_data = shifted[ELEMENT_W-1:0];
      end else if (rnd_ff[ACC_W-1]) begin
         sat_data = {1'b1, {(ELEMENT_W-1){1'b0}}};
      end else begin
         sat_data = {1'b0, {(ELEMENT_W-1){1'b1}}};
      end
   end

   assign result.valid = rnd_valid_ff;
   assign result.fin   = rnd_fin_ff;
   assign result.data  = sat_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_mul_ff   <= '0;
         ctl_acc_ff   <= '0;
         rnd_valid_ff <= 1'b0;
         rnd_fin_ff   <= 1'b0;
      end else begin
         ctl_mul_ff   <= op_ctl;
         ctl_acc_ff   <= ctl_mul_ff;
         rnd_valid_ff <= ctl_acc_ff.valid && ctl_acc_ff.last;
         rnd_fin_ff   <= ctl_acc_ff.fin;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= op_left * op_right;
      if (ctl_mul_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (ctl_acc_ff.valid && ctl_acc_ff.last) begin
         rnd_ff <= acc_ff + HALF;
      end
   end

endmodule
